/* rtl/core/pid_step_antiwindup_defines.svh */
// Assertion macros shared by the PID step controller RTL.
`ifndef PID_STEP_ANTIWINDUP_DEFINES_SVH
`define PID_STEP_ANTIWINDUP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define PSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define PSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/psa_pkg.sv */
// Types and constants of the PID step controller.
`default_nettype none
package psa_pkg;

  // input transfer payload
  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] measured;
    logic [23:0]        delta_time;
    logic signed [31:0] rate_given;
  } in_t;

  // result transfer payload
  typedef struct packed {
    logic signed [31:0] drive;
    logic               limited;
  } out_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV_RATE, S_MUL_I, S_MUL_D, S_SUM, S_MUL_P, S_GATE,
    S_MUL_DT, S_CLAMP_CHK, S_MUL_K, S_KPREP, S_DIV_B, S_ACLAMP, S_LIMIT, S_FINISH
  } state_t;

  // commands
  localparam logic [1:0] CMD_GIVEN  = 2'd0;
  localparam logic [1:0] CMD_DERIVE = 2'd1;

  // register indexes
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_TARGET    = 3'd3;
  localparam logic [2:0] REG_OUT_LIM   = 3'd4;
  localparam logic [2:0] REG_INTEG_LIM = 3'd5;

  // saturation bounds
  localparam logic signed [31:0] Q_MAX   = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [47:0] ACC_MAX = 48'sh7fff_ffff_ffff;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

  // serial engine: 49 one-bit steps, then the result stays settled until the next load
  localparam logic [5:0] ENG_LAST = 6'd48;
  localparam logic [5:0] ENG_DONE = 6'd49;

  // clamp a wide signed value to the Q16.16 range
  function automatic logic signed [31:0] sat32(input logic signed [80:0] v);
    logic signed [31:0] r;
    if (v > 81'(Q_MAX)) r = Q_MAX;
    else if (v < 81'(Q_MIN)) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/pid_step_antiwindup.sv */
// PID step controller with conditional-integration anti-windup, bit-serial datapath.
// Takes one item at a time: in_ready is high only while idle, and a stalled output holds
// the next result in the finish state. The shared 1-bit-per-cycle multiplier and restoring
// divider run five to nine operations per update; a reset command skips them.
// Reset (rst_n low, synchronous) loads gain_p 1.0, limits -1.0, others and state 0.
`default_nettype none
`include "pid_step_antiwindup_defines.svh"
module pid_step_antiwindup (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire psa_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output psa_pkg::out_t       out_data,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [31:0]    cfg_wdata
);

  psa_pkg::state_t state_r, state_nxt;

  // configuration
  logic signed [31:0] gp_r, gi_r, gd_r, tgt_r, ol_r, il_r;

  // controller state
  logic signed [47:0] acc_r, acc_nxt;
  logic signed [31:0] prev_r, prev_nxt;

  // captured item
  logic [1:0]         cmd_r, cmd_nxt;
  logic signed [31:0] meas_r, meas_nxt, rg_r, rg_nxt;
  logic [23:0]        dt_r, dt_nxt;

  // working terms
  logic signed [31:0] err_r, err_nxt, rate_r, rate_nxt, ti_r, ti_nxt, td_r, td_nxt;
  logic signed [31:0] resp_r, resp_nxt;
  logic [31:0]        kk_r, kk_nxt;
  logic signed [47:0] bound_r, bound_nxt;
  logic               neg_r, neg_nxt, pass2_r, pass2_nxt;
  psa_pkg::out_t      res_r, res_nxt, out_r, out_nxt;
  logic               ovalid_r, ovalid_nxt;

  // serial engine
  logic [5:0]         cnt_r, cnt_nxt;
  logic signed [48:0] mx_r, mx_nxt;
  logic signed [80:0] mm_r, mm_nxt, mp_r, mp_nxt;
  logic [48:0]        dq_r, dq_nxt;
  logic [31:0]        drem_r, drem_nxt, dd_r, dd_nxt;
  logic               mul_ld, div_ld;
  logic signed [48:0] mul_x;
  logic signed [31:0] mul_y;
  logic [48:0]        div_n;
  logic [31:0]        div_d;

  logic signed [80:0] msh;
  logic signed [31:0] mres;
  logic               done;
  logic [32:0]        dsh;
  logic               dge;

  // control-path temporaries
  logic signed [32:0] err_full, diff, diff_mag, resp_mag;
  logic signed [31:0] inner_v, mk;
  logic signed [49:0] acc_sum;
  logic signed [80:0] qs;
  logic               integ;

  assign in_ready  = (state_r == psa_pkg::S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = out_r;

  assign msh  = mp_r >>> 16;
  assign mres = psa_pkg::sat32(msh);
  assign done = (cnt_r == psa_pkg::ENG_DONE);

  // restoring divider step compare
  assign dsh = {drem_r, dq_r[48]};
  assign dge = (dsh >= {1'b0, dd_r});

  // engine next state: load, or one bit per cycle for both units
  always_comb begin
    mx_nxt = mx_r; mm_nxt = mm_r; mp_nxt = mp_r;
    dq_nxt = dq_r; drem_nxt = drem_r; dd_nxt = dd_r;
    cnt_nxt = cnt_r;
    if (mul_ld) begin
      mx_nxt = mul_x; mm_nxt = 81'(mul_y); mp_nxt = '0; cnt_nxt = '0;
    end else if (div_ld) begin
      dq_nxt = div_n; drem_nxt = '0; dd_nxt = div_d; cnt_nxt = '0;
    end else if (cnt_r < psa_pkg::ENG_DONE) begin
      // sign bit of the multiplier carries negative weight
      if (mx_r[0]) begin
        if (cnt_r == psa_pkg::ENG_LAST) mp_nxt = mp_r - mm_r;
        else mp_nxt = mp_r + mm_r;
      end
      mm_nxt = mm_r <<< 1;
      mx_nxt = mx_r >>> 1;
      drem_nxt = dge ? 32'(dsh - {1'b0, dd_r}) : dsh[31:0];
      dq_nxt = {dq_r[47:0], dge};
      cnt_nxt = cnt_r + 6'd1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    acc_nxt = acc_r; prev_nxt = prev_r;
    cmd_nxt = cmd_r; meas_nxt = meas_r; rg_nxt = rg_r; dt_nxt = dt_r;
    err_nxt = err_r; rate_nxt = rate_r; ti_nxt = ti_r; td_nxt = td_r;
    resp_nxt = resp_r; kk_nxt = kk_r; bound_nxt = bound_r;
    neg_nxt = neg_r; pass2_nxt = pass2_r; res_nxt = res_r; out_nxt = out_r;
    ovalid_nxt = ovalid_r && !out_ready;
    mul_ld = 1'b0; mul_x = '0; mul_y = '0;
    div_ld = 1'b0; div_n = '0; div_d = '0;
    err_full = 33'(tgt_r) - 33'(meas_r);
    diff     = 33'(meas_r) - 33'(prev_r);
    diff_mag = diff[32] ? -diff : diff;
    resp_mag = resp_r[31] ? -33'(resp_r) : 33'(resp_r);
    inner_v  = psa_pkg::sat32(81'(err_r) + 81'(ti_r) - 81'(td_r));
    acc_sum  = 50'(acc_r) + 50'(msh);
    qs       = neg_r ? -81'(dq_r) : 81'(dq_r);
    mk       = mres;
    integ    = ol_r[31] || (resp_mag < 33'(ol_r)) ||
               ((acc_r != '0) && (acc_r[47] != err_r[31]));
    unique case (state_r)
      psa_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_data.command;
          meas_nxt = in_data.measured;
          dt_nxt   = in_data.delta_time;
          rg_nxt   = in_data.rate_given;
          state_nxt = psa_pkg::S_PREP;
        end
      end
      psa_pkg::S_PREP: begin
        pass2_nxt = 1'b0;
        if (cmd_r != psa_pkg::CMD_GIVEN && cmd_r != psa_pkg::CMD_DERIVE) begin
          acc_nxt = '0; prev_nxt = '0; res_nxt = '0;
          state_nxt = psa_pkg::S_FINISH;
        end else begin
          err_nxt  = psa_pkg::sat32(81'(err_full));
          prev_nxt = meas_r;
          if (cmd_r == psa_pkg::CMD_DERIVE && dt_r != '0) begin
            neg_nxt = diff[32];
            div_ld = 1'b1; div_n = {diff_mag[32:0], 16'b0}; div_d = {8'b0, dt_r};
            state_nxt = psa_pkg::S_DIV_RATE;
          end else begin
            if (cmd_r == psa_pkg::CMD_GIVEN) rate_nxt = rg_r;
            else if (diff > 33'sd0) rate_nxt = psa_pkg::Q_MAX;
            else if (diff < 33'sd0) rate_nxt = psa_pkg::Q_MIN;
            else rate_nxt = '0;
            mul_ld = 1'b1; mul_x = 49'(acc_r); mul_y = gi_r;
            state_nxt = psa_pkg::S_MUL_I;
          end
        end
      end
      psa_pkg::S_DIV_RATE: begin
        if (done) begin
          rate_nxt = psa_pkg::sat32(qs);
          mul_ld = 1'b1; mul_x = 49'(acc_r); mul_y = gi_r;
          state_nxt = psa_pkg::S_MUL_I;
        end
      end
      psa_pkg::S_MUL_I: begin
        if (done) begin
          ti_nxt = mres;
          if (pass2_r) begin
            state_nxt = psa_pkg::S_SUM;
          end else begin
            mul_ld = 1'b1; mul_x = 49'(rate_r); mul_y = gd_r;
            state_nxt = psa_pkg::S_MUL_D;
          end
        end
      end
      psa_pkg::S_MUL_D: begin
        if (done) begin
          td_nxt = mres;
          state_nxt = psa_pkg::S_SUM;
        end
      end
      psa_pkg::S_SUM: begin
        mul_ld = 1'b1; mul_x = 49'(inner_v); mul_y = gp_r;
        state_nxt = psa_pkg::S_MUL_P;
      end
      psa_pkg::S_MUL_P: begin
        if (done) begin
          resp_nxt = mres;
          state_nxt = pass2_r ? psa_pkg::S_LIMIT : psa_pkg::S_GATE;
        end
      end
      psa_pkg::S_GATE: begin
        if (integ) begin
          mul_ld = 1'b1; mul_x = 49'({25'b0, dt_r}); mul_y = err_r;
          state_nxt = psa_pkg::S_MUL_DT;
        end else begin
          state_nxt = psa_pkg::S_CLAMP_CHK;
        end
      end
      psa_pkg::S_MUL_DT: begin
        if (done) begin
          if (acc_sum > 50'(psa_pkg::ACC_MAX)) acc_nxt = psa_pkg::ACC_MAX;
          else if (acc_sum < 50'(psa_pkg::ACC_MIN)) acc_nxt = psa_pkg::ACC_MIN;
          else acc_nxt = acc_sum[47:0];
          state_nxt = psa_pkg::S_CLAMP_CHK;
        end
      end
      psa_pkg::S_CLAMP_CHK: begin
        if (!il_r[31] && !gi_r[31] && gi_r != '0) begin
          mul_ld = 1'b1; mul_x = 49'(gp_r); mul_y = gi_r;
          state_nxt = psa_pkg::S_MUL_K;
        end else begin
          pass2_nxt = 1'b1;
          mul_ld = 1'b1; mul_x = 49'(acc_r); mul_y = gi_r;
          state_nxt = psa_pkg::S_MUL_I;
        end
      end
      psa_pkg::S_MUL_K: begin
        if (done) begin
          kk_nxt = mk[31] ? 32'(-33'(mk)) : 32'(mk);
          state_nxt = psa_pkg::S_KPREP;
        end
      end
      psa_pkg::S_KPREP: begin
        if (kk_r == '0) begin
          pass2_nxt = 1'b1;
          mul_ld = 1'b1; mul_x = 49'(acc_r); mul_y = gi_r;
          state_nxt = psa_pkg::S_MUL_I;
        end else begin
          div_ld = 1'b1; div_n = {2'b0, il_r[30:0], 16'b0}; div_d = kk_r;
          state_nxt = psa_pkg::S_DIV_B;
        end
      end
      psa_pkg::S_DIV_B: begin
        if (done) begin
          bound_nxt = dq_r[47:0];
          state_nxt = psa_pkg::S_ACLAMP;
        end
      end
      psa_pkg::S_ACLAMP: begin
        if (acc_r > bound_r) acc_nxt = bound_r;
        else if (acc_r < -bound_r) acc_nxt = -bound_r;
        pass2_nxt = 1'b1;
        mul_ld = 1'b1; mul_x = 49'(acc_nxt); mul_y = gi_r;
        state_nxt = psa_pkg::S_MUL_I;
      end
      psa_pkg::S_LIMIT: begin
        res_nxt.drive = resp_r;
        res_nxt.limited = 1'b0;
        if (!ol_r[31] && resp_mag >= 33'(ol_r)) begin
          res_nxt.limited = 1'b1;
          if (resp_r > ol_r) res_nxt.drive = ol_r;
          else if (resp_r < -ol_r) res_nxt.drive = -ol_r;
        end
        state_nxt = psa_pkg::S_FINISH;
      end
      psa_pkg::S_FINISH: begin
        if (!ovalid_r || out_ready) begin
          out_nxt = res_r;
          ovalid_nxt = 1'b1;
          state_nxt = psa_pkg::S_IDLE;
        end
      end
      default: state_nxt = psa_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control, configuration and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      cnt_r    <= psa_pkg::ENG_DONE;
      acc_r    <= '0;
      prev_r   <= '0;
      pass2_r  <= 1'b0;
      gp_r     <= 32'sd65536;
      gi_r     <= '0;
      gd_r     <= '0;
      tgt_r    <= '0;
      ol_r     <= -32'sd65536;
      il_r     <= -32'sd65536;
    end else begin
      ovalid_r <= ovalid_nxt;
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      prev_r   <= prev_nxt;
      pass2_r  <= pass2_nxt;
      if (cfg_we) begin
        case (cfg_index)
          psa_pkg::REG_GAIN_P:    gp_r  <= cfg_wdata;
          psa_pkg::REG_GAIN_I:    gi_r  <= cfg_wdata;
          psa_pkg::REG_GAIN_D:    gd_r  <= cfg_wdata;
          psa_pkg::REG_TARGET:    tgt_r <= cfg_wdata;
          psa_pkg::REG_OUT_LIM:   ol_r  <= cfg_wdata;
          psa_pkg::REG_INTEG_LIM: il_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; meas_r <= meas_nxt; rg_r <= rg_nxt; dt_r <= dt_nxt;
    err_r <= err_nxt; rate_r <= rate_nxt; ti_r <= ti_nxt; td_r <= td_nxt;
    resp_r <= resp_nxt; kk_r <= kk_nxt; bound_r <= bound_nxt; neg_r <= neg_nxt;
    res_r <= res_nxt; out_r <= out_nxt;
    mx_r <= mx_nxt; mm_r <= mm_nxt; mp_r <= mp_nxt;
    dq_r <= dq_nxt; drem_r <= drem_nxt; dd_r <= dd_nxt;
  end

  // checks
  `PSA_ASSERT_NXT(a_acc_clamped, state_r == psa_pkg::S_ACLAMP,
    (acc_r <= bound_r) && (acc_r >= -bound_r), "accumulator outside clamp bound")
  `PSA_ASSERT_IMP(a_limit_value, ovalid_r && out_r.limited,
    (out_r.drive == ol_r) || (out_r.drive == -ol_r), "limited drive not at limit")
  `PSA_ASSERT_NXT(a_reset_cmd,
    state_r == psa_pkg::S_PREP && cmd_r != psa_pkg::CMD_GIVEN && cmd_r != psa_pkg::CMD_DERIVE,
    (acc_r == '0) && (prev_r == '0), "reset command left state")

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench of the PID step controller with conditional-integration anti-windup.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_CLEAR_ALT = 2'd3;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint AMAX = 64'sd140737488355327;
  localparam longint AMIN = -64'sd140737488355328;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  psa_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  psa_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  pid_step_antiwindup dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // controller copy: registers and state
  longint kp, ki, kd, setpt, out_lim, int_lim;
  longint acc, prev_meas;

  psa_pkg::in_t    pending_items[$];
  psa_pkg::out_t   expected_drive[$];
  int     errors = 0;
  bit     calm = 1'b0;
  int     quiet_cycles = 0;

  function automatic longint floor_sh(longint x);
    return x >>> 16;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clip(floor_sh(a * b), QMIN, QMAX);
  endfunction

  // gain times 48-bit accumulator, split to stay in 64 bits
  function automatic longint acc_mul(longint g, longint a);
    longint hi, lo;
    hi = floor_sh(a);
    lo = a - hi * 65536;
    return clip(hi * g + floor_sh(lo * g), QMIN, QMAX);
  endfunction

  function automatic longint absv(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint response(longint e, longint r);
    return qmul(kp, clip(e + acc_mul(ki, acc) - qmul(kd, r), QMIN, QMAX));
  endfunction

  // one controller step; updates accumulator and previous measurement
  function automatic psa_pkg::out_t pid_step(psa_pkg::in_t it);
    psa_pkg::out_t o;
    longint m, dt, r, e, resp, diff, kk, bound;
    o = '0;
    if (it.command == CMD_CLEAR || it.command == CMD_CLEAR_ALT) begin
      acc = 0;
      prev_meas = 0;
      return o;
    end
    m = longint'(it.measured);
    dt = longint'(it.delta_time);
    if (it.command == psa_pkg::CMD_GIVEN) r = longint'(it.rate_given);
    else begin
      diff = m - prev_meas;
      if (dt == 0) r = diff > 0 ? QMAX : (diff < 0 ? QMIN : 0);
      else r = clip((diff * 65536) / dt, QMIN, QMAX);
    end
    e = clip(setpt - m, QMIN, QMAX);
    prev_meas = m;
    resp = response(e, r);
    if (out_lim < 0 || absv(resp) < out_lim || (acc != 0 && ((acc < 0) != (e < 0))))
      acc = clip(acc + floor_sh(e * dt), AMIN, AMAX);
    if (int_lim >= 0 && ki > 0) begin
      kk = absv(qmul(kp, ki));
      if (kk != 0) begin
        bound = clip((int_lim * 65536) / kk, 0, AMAX);
        acc = clip(acc, -bound, bound);
      end
    end
    resp = response(e, r);
    if (out_lim >= 0 && absv(resp) >= out_lim) begin
      resp = clip(resp, -out_lim, out_lim);
      o.limited = 1'b1;
    end
    o.drive = resp[31:0];
    return o;
  endfunction

  function automatic int idle_pct();
    return calm ? 0 : 24;
  endfunction

  // driver: presents queued items, keeps valid until transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid) expected_drive.push_back(pid_step(in_data));
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct()) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor: compares each result transfer with the oldest expectation
  always @(posedge clk) begin
    psa_pkg::out_t exp_o;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          $error("result with no expectation: drive %0d", out_data.drive);
          errors++;
        end else begin
          exp_o = expected_drive.pop_front();
          if (out_data.drive !== exp_o.drive) begin
            $error("drive expected %0d actual %0d", exp_o.drive, out_data.drive);
            errors++;
          end
          if (out_data.limited !== exp_o.limited) begin
            $error("limited expected %0b actual %0b", exp_o.limited, out_data.limited);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct());
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[31:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      psa_pkg::REG_GAIN_P:    kp = longint'(signed'(val[31:0]));
      psa_pkg::REG_GAIN_I:    ki = longint'(signed'(val[31:0]));
      psa_pkg::REG_GAIN_D:    kd = longint'(signed'(val[31:0]));
      psa_pkg::REG_TARGET:    setpt = longint'(signed'(val[31:0]));
      psa_pkg::REG_OUT_LIM:   out_lim = longint'(signed'(val[31:0]));
      psa_pkg::REG_INTEG_LIM: int_lim = longint'(signed'(val[31:0]));
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_drive.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic psa_pkg::in_t make_item(logic [1:0] c, longint m, longint dt,
                                              longint r);
    psa_pkg::in_t it;
    it.command = c;
    it.measured = m[31:0];
    it.delta_time = dt[23:0];
    it.rate_given = r[31:0];
    return it;
  endfunction

  // mostly modest values, sometimes full range
  function automatic longint rnd_q();
    case ($urandom_range(3))
      0: return longint'($signed($urandom()));
      default: return longint'($urandom_range(0, 20 * 65536)) - 10 * 65536;
    endcase
  endfunction

  function automatic longint rnd_dt();
    case ($urandom_range(5))
      0: return 0;
      1: return longint'($urandom_range(0, 24'hffffff));
      default: return longint'($urandom_range(1, 65536));
    endcase
  endfunction

  function automatic longint rnd_gain();
    case ($urandom_range(4))
      0: return longint'($signed($urandom()));
      1: return 0;
      default: return longint'($urandom_range(0, 8 * 65536)) - 2 * 65536;
    endcase
  endfunction

  function automatic longint rnd_lim();
    case ($urandom_range(4))
      0: return -65536;
      1: return 0;
      2: return longint'($signed($urandom()));
      default: return longint'($urandom_range(0, 30 * 65536));
    endcase
  endfunction

  initial begin
    int phase;
    kp = 65536; ki = 0; kd = 0; setpt = 0; out_lim = -65536; int_lim = -65536;
    acc = 0; prev_meas = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset values, extremes, every command and special case
    pending_items.push_back(make_item(psa_pkg::CMD_GIVEN, 65536, 65536, 0));
    pending_items.push_back(make_item(psa_pkg::CMD_DERIVE, 3 * 65536, 0, -1));
    pending_items.push_back(make_item(psa_pkg::CMD_DERIVE, 3 * 65536, 0, 0));
    pending_items.push_back(make_item(psa_pkg::CMD_DERIVE, -65536, 0, 0));
    pending_items.push_back(make_item(psa_pkg::CMD_DERIVE, QMAX, 24'hffffff, 0));
    pending_items.push_back(make_item(psa_pkg::CMD_GIVEN, QMIN, 24'hffffff, QMAX));
    pending_items.push_back(make_item(psa_pkg::CMD_GIVEN, QMAX, 1, QMIN));
    pending_items.push_back(make_item(CMD_CLEAR, QMAX, 24'hffffff, -1));
    pending_items.push_back(make_item(CMD_CLEAR_ALT, -1, 5, 5));
    drain();
    write_reg(psa_pkg::REG_GAIN_P, 2 * 65536);
    write_reg(psa_pkg::REG_GAIN_I, 65536);
    write_reg(psa_pkg::REG_GAIN_D, 32768);
    write_reg(psa_pkg::REG_TARGET, 5 * 65536);
    write_reg(psa_pkg::REG_OUT_LIM, 3 * 65536);
    write_reg(psa_pkg::REG_INTEG_LIM, 65536);
    // saturate, then error opposing accumulator, zero error with negative acc
    for (int i = 0; i < 4; i++)
      pending_items.push_back(make_item(psa_pkg::CMD_DERIVE, 0, 65536, 0));
    pending_items.push_back(make_item(psa_pkg::CMD_GIVEN, 20 * 65536, 65536, 0));
    pending_items.push_back(make_item(psa_pkg::CMD_GIVEN, 20 * 65536, 65536, 0));
    pending_items.push_back(make_item(psa_pkg::CMD_GIVEN, 5 * 65536, 65536, 0));
    drain();
    write_reg(psa_pkg::REG_OUT_LIM, 0);
    write_reg(psa_pkg::REG_GAIN_I, -65536);
    pending_items.push_back(make_item(psa_pkg::CMD_GIVEN, 5 * 65536, 65536, 0));
    pending_items.push_back(make_item(psa_pkg::CMD_DERIVE, 4 * 65536, 100, 0));
    drain();
    write_reg(psa_pkg::REG_GAIN_P, 0);
    write_reg(psa_pkg::REG_GAIN_I, QMAX);
    write_reg(psa_pkg::REG_INTEG_LIM, QMAX);
    write_reg(psa_pkg::REG_OUT_LIM, QMAX);
    pending_items.push_back(make_item(psa_pkg::CMD_GIVEN, QMIN, 24'hffffff, 0));
    pending_items.push_back(make_item(psa_pkg::CMD_GIVEN, QMAX, 1, QMIN));
    drain();
    write_reg(psa_pkg::REG_GAIN_P, QMIN);
    write_reg(psa_pkg::REG_GAIN_D, QMIN);
    write_reg(psa_pkg::REG_TARGET, QMIN);
    write_reg(psa_pkg::REG_OUT_LIM, QMIN);
    write_reg(psa_pkg::REG_INTEG_LIM, QMIN);
    pending_items.push_back(make_item(psa_pkg::CMD_DERIVE, QMAX, 1, 0));
    pending_items.push_back(make_item(psa_pkg::CMD_GIVEN, QMIN, 65536, QMAX));
    drain();

    // random phases: new settings, then sequences of updates with occasional clears
    for (phase = 0; phase < 13; phase++) begin
      write_reg(psa_pkg::REG_GAIN_P, rnd_gain());
      write_reg(psa_pkg::REG_GAIN_I, rnd_gain());
      write_reg(psa_pkg::REG_GAIN_D, rnd_gain());
      write_reg(psa_pkg::REG_TARGET, rnd_q());
      write_reg(psa_pkg::REG_OUT_LIM, rnd_lim());
      write_reg(psa_pkg::REG_INTEG_LIM, rnd_lim());
      calm = (phase == 6);
      for (int i = 0; i < 100; i++) begin
        case ($urandom_range(19))
          0: pending_items.push_back(make_item(CMD_CLEAR, rnd_q(),
                 longint'($urandom_range(0, 24'hffffff)), rnd_q()));
          1: pending_items.push_back(make_item(CMD_CLEAR_ALT, rnd_q(), rnd_dt(), rnd_q()));
          2, 3, 4, 5, 6, 7, 8: pending_items.push_back(make_item(psa_pkg::CMD_GIVEN,
                 rnd_q(), rnd_dt(), rnd_q()));
          default: pending_items.push_back(make_item(psa_pkg::CMD_DERIVE, rnd_q(),
                 rnd_dt(), rnd_q()));
        endcase
      end
      drain();
      calm = 1'b0;
    end

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/psa_pkg.sv
rtl/core/pid_step_antiwindup.sv
tb/sv/testbench.sv
